FILE: rtl/core/hslargb_pkg.sv
// ----------------------------------------------------------------------------
// hslargb_pkg
// Shared widths and constants for the HSLA to packed ARGB converter.
// ----------------------------------------------------------------------------
package hslargb_pkg;

    // Input formats
    localparam int IN_W      = 24;
    localparam int FRAC_BITS = 12;
    localparam int MAG_W     = IN_W - 1;
    localparam int ONE_IN    = 1 << FRAC_BITS;
    localparam int PCT_LIMIT = 100 * ONE_IN;

    // Internal unit format for saturation and lightness
    localparam int IFRAC     = 28;
    localparam int UNIT_W    = IFRAC + 1;
    localparam int PCT_SHIFT = IFRAC - FRAC_BITS;
    localparam logic [UNIT_W-1:0] ONE_INT  = UNIT_W'(1) << IFRAC;
    localparam logic [UNIT_W-1:0] HALF_INT = UNIT_W'(1) << (IFRAC - 1);

    // Percent scaling: x * 2^PCT_SHIFT / 100 == x * 2^(PCT_SHIFT-2) / 25
    localparam int PCT_DIV     = 25;
    localparam int PCT_K_SHIFT = 28;
    localparam int PCT_K_W     = 24;
    localparam logic [PCT_K_W-1:0] PCT_K = PCT_K_W'((1 << PCT_K_SHIFT) / PCT_DIV);
    localparam int PCT_PROD_W  = MAG_W + PCT_K_W;
    localparam int PCT_Q_W     = PCT_PROD_W - PCT_K_SHIFT;
    localparam int PCT_REM_W   = 6;
    localparam int PCT_WIDE_W  = 48;
    localparam int PCT_FRAC_SHIFT = 24;
    localparam int PCT_FRAC_K     = ((1 << PCT_FRAC_SHIFT) + PCT_DIV - 1) / PCT_DIV;

    // Hue in 1/64 degree units
    localparam int HUE_TURN  = 23040;
    localparam int HUE_THIRD = 7680;
    localparam int HUE_SIXTH = 3840;
    localparam int HUE_W     = 15;
    localparam int HUE_X_W   = 17;
    localparam int WGT_W     = 12;
    localparam int HUE_LOW   = 9;
    localparam int HUE_MOD   = HUE_TURN >> HUE_LOW;
    localparam int HV_W      = 25;
    localparam int HU_W      = HV_W - HUE_LOW;
    localparam logic [HV_W-1:0] HUE_BIAS = HV_W'(HUE_TURN * 365);
    localparam int MOD_K_SHIFT = 21;
    localparam int MOD_PROD_W  = 32;
    localparam logic [MOD_PROD_W-1:0] MOD_K = MOD_PROD_W'((1 << MOD_K_SHIFT) / HUE_MOD);
    localparam int MOD_Q_W     = MOD_PROD_W - MOD_K_SHIFT;
    localparam int HUE_REM_W   = 7;

    // Lightness/saturation product and intermediates
    localparam int SEL_W  = UNIT_W + 1;
    localparam int PROD_W = UNIT_W + SEL_W;
    localparam int M_W    = UNIT_W + 2;

    // Channel scaling and rounding
    localparam int SUM_W     = UNIT_W + WGT_W;
    localparam int Y_W       = SUM_W + 8;
    localparam int DEN_SHIFT = IFRAC + 8;
    localparam int Z_W       = Y_W - DEN_SHIFT;
    localparam logic [Y_W-1:0] ROUND_BIAS = Y_W'(HUE_SIXTH / 2) << IFRAC;
    localparam int DIV15_K     = 4370;
    localparam int DIV15_SHIFT = 16;
    localparam int Q15_W       = 2 * Z_W;

    // Alpha
    localparam int ALPHA_W = FRAC_BITS + 9;

    // Register stages from accept to result
    localparam int PIPE_DEPTH = 8;

endpackage

FILE: rtl/core/hslargb_unit.sv
// ----------------------------------------------------------------------------
// hslargb_unit
// Two-stage normalizer: maps a saturation or lightness input to the internal
// unit format, reading values above one as percent and clamping to 0..1.
// ----------------------------------------------------------------------------
module hslargb_unit (
    input  logic                                    i_clk,
    input  logic signed [hslargb_pkg::IN_W-1:0]     i_raw,
    output logic        [hslargb_pkg::UNIT_W-1:0]   o_value
);

    typedef enum logic [1:0] {
        UC_ZERO,
        UC_DIRECT,
        UC_PCT,
        UC_ONE
    } t_unit_cls;

    // divide by 25 with a reciprocal product; exact over the whole remainder range
    function automatic logic [hslargb_pkg::UNIT_W-1:0] pct_frac(
        input logic [hslargb_pkg::PCT_REM_W-1:0] rem
    );
        logic [hslargb_pkg::PCT_WIDE_W-1:0] t;
        t = (hslargb_pkg::PCT_WIDE_W'(rem) << (hslargb_pkg::PCT_SHIFT - 2))
            * hslargb_pkg::PCT_WIDE_W'(hslargb_pkg::PCT_FRAC_K);
        return hslargb_pkg::UNIT_W'(t >> hslargb_pkg::PCT_FRAC_SHIFT);
    endfunction

    logic signed [31:0]                         raw_ext;
    t_unit_cls                                  n_cls;
    logic [hslargb_pkg::PCT_PROD_W-1:0]         n_prod;

    t_unit_cls                                  r_cls;
    logic [hslargb_pkg::MAG_W-1:0]              r_mag;
    logic [hslargb_pkg::PCT_PROD_W-1:0]         r_prod;
    logic [hslargb_pkg::UNIT_W-1:0]             r_value;

    logic [hslargb_pkg::PCT_Q_W-1:0]            q_est;
    logic [hslargb_pkg::MAG_W-1:0]              rem_full;
    logic [hslargb_pkg::PCT_Q_W-1:0]            q_fix;
    logic [hslargb_pkg::PCT_REM_W-1:0]          rem_fix;
    logic [hslargb_pkg::PCT_WIDE_W-1:0]         pct_val;
    logic [hslargb_pkg::UNIT_W-1:0]             n_value;

    // Stage A: classify and start the divide by 25 with a reciprocal product
    assign raw_ext = 32'(i_raw);

    always_comb begin
        if (i_raw[hslargb_pkg::IN_W-1]) begin
            n_cls = UC_ZERO;
        end else if (raw_ext <= 32'(hslargb_pkg::ONE_IN)) begin
            n_cls = UC_DIRECT;
        end else if (raw_ext > 32'(hslargb_pkg::PCT_LIMIT)) begin
            n_cls = UC_ONE;
        end else begin
            n_cls = UC_PCT;
        end
        n_prod = hslargb_pkg::PCT_PROD_W'(i_raw[hslargb_pkg::MAG_W-1:0])
                 * hslargb_pkg::PCT_PROD_W'(hslargb_pkg::PCT_K);
    end

    always_ff @(posedge i_clk) begin
        r_cls  <= n_cls;
        r_mag  <= i_raw[hslargb_pkg::MAG_W-1:0];
        r_prod <= n_prod;
    end

    // Stage B: correct the quotient estimate, add the remainder fraction
    always_comb begin
        q_est    = r_prod[hslargb_pkg::PCT_PROD_W-1:hslargb_pkg::PCT_K_SHIFT];
        rem_full = r_mag - hslargb_pkg::MAG_W'(hslargb_pkg::MAG_W'(q_est)
                   * hslargb_pkg::MAG_W'(hslargb_pkg::PCT_DIV));
        if (rem_full >= hslargb_pkg::MAG_W'(hslargb_pkg::PCT_DIV)) begin
            q_fix   = q_est + 1'b1;
            rem_fix = hslargb_pkg::PCT_REM_W'(rem_full
                      - hslargb_pkg::MAG_W'(hslargb_pkg::PCT_DIV));
        end else begin
            q_fix   = q_est;
            rem_fix = rem_full[hslargb_pkg::PCT_REM_W-1:0];
        end
        pct_val = (hslargb_pkg::PCT_WIDE_W'(q_fix) << (hslargb_pkg::PCT_SHIFT - 2))
                  + hslargb_pkg::PCT_WIDE_W'(pct_frac(rem_fix));
        case (r_cls)
            UC_ZERO:   n_value = '0;
            UC_DIRECT: n_value = hslargb_pkg::UNIT_W'(r_mag) << hslargb_pkg::PCT_SHIFT;
            UC_PCT:    n_value = pct_val[hslargb_pkg::UNIT_W-1:0];
            UC_ONE:    n_value = hslargb_pkg::ONE_INT;
            default:   n_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

FILE: rtl/core/hslargb_chan.sv
// ----------------------------------------------------------------------------
// hslargb_chan
// Four-stage color channel: blends m1 and m2 by the hue weight, scales by 255
// and rounds half up to one byte.
// ----------------------------------------------------------------------------
module hslargb_chan (
    input  logic                                 i_clk,
    input  logic [hslargb_pkg::UNIT_W-1:0]       i_m1,
    input  logic [hslargb_pkg::UNIT_W-1:0]       i_d,
    input  logic [hslargb_pkg::WGT_W-1:0]        i_w,
    output logic [7:0]                           o_byte
);

    logic [hslargb_pkg::SUM_W-1:0]   r_prod;
    logic [hslargb_pkg::SUM_W-1:0]   r_base;
    logic [hslargb_pkg::SUM_W-1:0]   r_sum;
    logic [hslargb_pkg::Z_W-1:0]     r_z;
    logic [7:0]                      r_byte;

    logic [hslargb_pkg::Y_W-1:0]     n_y;
    logic [hslargb_pkg::Q15_W-1:0]   n_q15;
    logic [hslargb_pkg::Q15_W-hslargb_pkg::DIV15_SHIFT-1:0] n_quo;
    logic [7:0]                      n_byte;

    // m1 * 3840 + (m2 - m1) * w, then num/den with den = 15 * 2^(IFRAC+8)
    always_comb begin
        n_y   = (hslargb_pkg::Y_W'(r_sum) << 8) - hslargb_pkg::Y_W'(r_sum)
                + hslargb_pkg::ROUND_BIAS;
        n_q15 = hslargb_pkg::Q15_W'(r_z) * hslargb_pkg::Q15_W'(hslargb_pkg::DIV15_K);
        n_quo = n_q15[hslargb_pkg::Q15_W-1:hslargb_pkg::DIV15_SHIFT];
        if (n_quo > 255) begin
            n_byte = 8'hff;
        end else begin
            n_byte = n_quo[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= hslargb_pkg::SUM_W'(i_d) * hslargb_pkg::SUM_W'(i_w);
        r_base <= (hslargb_pkg::SUM_W'(i_m1) << 12) - (hslargb_pkg::SUM_W'(i_m1) << 8);
        r_sum  <= r_prod + r_base;
        r_z    <= n_y[hslargb_pkg::Y_W-1:hslargb_pkg::DEN_SHIFT];
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

FILE: rtl/core/hsla_to_argb_converter.sv
// ----------------------------------------------------------------------------
// hsla_to_argb_converter
// HSLA (fixed point) to packed 32-bit ARGB color, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: drive hue, saturation, lightness and opacity with start high.
//   A beat is taken on any rising edge with start high and busy low. busy is
//   high only while reset is asserted, so a new beat may enter every cycle.
//   Result beat: o_valid is high for one cycle with o_argb_word; results
//   pass eight register stages and leave in input order.
//   Throughput is one pixel per clock; the stage depth is set by the hue
//   reduction, the percent divide, the lightness product and the per-channel
//   blend, scale and rounding chain.
//   The receiver cannot stall: every result must be taken in its cycle.
//   Reset (synchronous, active low) clears all valid bits; beats in flight
//   are dropped and no result appears until new beats arrive.
// ----------------------------------------------------------------------------
module hsla_to_argb_converter (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [hslargb_pkg::IN_W-1:0]     i_hue_deg,
    input  logic signed [hslargb_pkg::IN_W-1:0]     i_saturation,
    input  logic signed [hslargb_pkg::IN_W-1:0]     i_lightness,
    input  logic signed [hslargb_pkg::IN_W-1:0]     i_opacity,
    output logic                                    o_valid,
    output logic [31:0]                             o_argb_word
);

    logic                                   accept;
    logic [hslargb_pkg::PIPE_DEPTH-1:0]     r_vld;
    logic [7:0]                             r_alpha [hslargb_pkg::PIPE_DEPTH];

    // Stage 1
    logic [hslargb_pkg::HV_W-1:0]           n1_hv;
    logic [hslargb_pkg::FRAC_BITS:0]        n1_a;
    logic [hslargb_pkg::ALPHA_W-1:0]        n1_ascaled;
    logic [hslargb_pkg::HUE_LOW-1:0]        r1_hlow;
    logic [hslargb_pkg::HU_W-1:0]           r1_hu;
    logic [hslargb_pkg::MOD_PROD_W-1:0]     r1_hprod;

    // Stage 2
    logic [hslargb_pkg::MOD_Q_W-1:0]        n2_q;
    logic [hslargb_pkg::HU_W-1:0]           n2_rem;
    logic [hslargb_pkg::HUE_REM_W-1:0]      n2_rem_fix;
    logic [hslargb_pkg::HUE_W-1:0]          r2_hue;
    logic [hslargb_pkg::UNIT_W-1:0]         w2_sat;
    logic [hslargb_pkg::UNIT_W-1:0]         w2_lit;

    // Stage 3
    logic signed [hslargb_pkg::HUE_X_W-1:0] n3_x [3];
    logic [hslargb_pkg::WGT_W-1:0]          n3_w [3];
    logic [hslargb_pkg::SEL_W-1:0]          n3_sel;
    logic                                   n3_low;
    logic [hslargb_pkg::PROD_W-1:0]         r3_prod;
    logic [hslargb_pkg::UNIT_W-1:0]         r3_l;
    logic [hslargb_pkg::UNIT_W-1:0]         r3_s;
    logic                                   r3_low;
    logic [hslargb_pkg::WGT_W-1:0]          r3_w [3];

    // Stage 4
    logic signed [hslargb_pkg::M_W-1:0]     n4_l;
    logic signed [hslargb_pkg::M_W-1:0]     n4_s;
    logic signed [hslargb_pkg::M_W-1:0]     n4_ps;
    logic signed [hslargb_pkg::M_W-1:0]     n4_m2;
    logic signed [hslargb_pkg::M_W-1:0]     n4_m1;
    logic signed [hslargb_pkg::M_W-1:0]     n4_d;
    logic [hslargb_pkg::UNIT_W-1:0]         r4_m1;
    logic [hslargb_pkg::UNIT_W:0]           r4_d;
    logic [hslargb_pkg::WGT_W-1:0]          r3_w_hold [3];

    logic [7:0]                             w8_rgb [3];

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[hslargb_pkg::PIPE_DEPTH-2:0], accept};
        end
    end

    // ---------------- Stage 1: hue bias, mod-45 reciprocal, alpha ----------
    always_comb begin
        // bias by whole turns so the floor modulo works on a positive value
        n1_hv = hslargb_pkg::HV_W'(i_hue_deg) + hslargb_pkg::HUE_BIAS;
        if (i_opacity[hslargb_pkg::IN_W-1]) begin
            n1_a = '0;
        end else if (i_opacity > hslargb_pkg::IN_W'(hslargb_pkg::ONE_IN)) begin
            n1_a = (hslargb_pkg::FRAC_BITS+1)'(hslargb_pkg::ONE_IN);
        end else begin
            n1_a = i_opacity[hslargb_pkg::FRAC_BITS:0];
        end
        n1_ascaled = hslargb_pkg::ALPHA_W'(n1_a) * hslargb_pkg::ALPHA_W'(255)
                     + hslargb_pkg::ALPHA_W'(hslargb_pkg::ONE_IN / 2);
    end

    always_ff @(posedge i_clk) begin
        r1_hlow    <= n1_hv[hslargb_pkg::HUE_LOW-1:0];
        r1_hu      <= n1_hv[hslargb_pkg::HV_W-1:hslargb_pkg::HUE_LOW];
        r1_hprod   <= hslargb_pkg::MOD_PROD_W'(n1_hv[hslargb_pkg::HV_W-1:hslargb_pkg::HUE_LOW])
                      * hslargb_pkg::MOD_K;
        r_alpha[0] <= n1_ascaled[hslargb_pkg::FRAC_BITS+7:hslargb_pkg::FRAC_BITS];
        for (int k = 1; k < hslargb_pkg::PIPE_DEPTH; k++) begin
            r_alpha[k] <= r_alpha[k-1];
        end
    end

    hslargb_unit u_sat (
        .i_clk   (i_clk),
        .i_raw   (i_saturation),
        .o_value (w2_sat)
    );

    hslargb_unit u_lit (
        .i_clk   (i_clk),
        .i_raw   (i_lightness),
        .o_value (w2_lit)
    );

    // ---------------- Stage 2: finish hue reduction ------------------------
    always_comb begin
        n2_q   = r1_hprod[hslargb_pkg::MOD_PROD_W-1:hslargb_pkg::MOD_K_SHIFT];
        n2_rem = r1_hu - hslargb_pkg::HU_W'(hslargb_pkg::HU_W'(n2_q)
                 * hslargb_pkg::HU_W'(hslargb_pkg::HUE_MOD));
        if (n2_rem >= hslargb_pkg::HU_W'(hslargb_pkg::HUE_MOD)) begin
            n2_rem_fix = hslargb_pkg::HUE_REM_W'(n2_rem
                         - hslargb_pkg::HU_W'(hslargb_pkg::HUE_MOD));
        end else begin
            n2_rem_fix = n2_rem[hslargb_pkg::HUE_REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r2_hue <= {n2_rem_fix[hslargb_pkg::HUE_W-hslargb_pkg::HUE_LOW-1:0], r1_hlow};
    end

    // ---------------- Stage 3: l*s or l*(1+s) product, hue weights -------
    always_comb begin
        n3_low = (w2_lit <= hslargb_pkg::HALF_INT);
        n3_sel = n3_low ? (hslargb_pkg::SEL_W'(w2_sat) + hslargb_pkg::SEL_W'(hslargb_pkg::ONE_INT))
                        : hslargb_pkg::SEL_W'(w2_sat);

        // red at +1/3 turn, green at hue, blue at -1/3 turn
        n3_x[0] = $signed({2'b00, r2_hue}) + hslargb_pkg::HUE_X_W'(hslargb_pkg::HUE_THIRD);
        n3_x[1] = $signed({2'b00, r2_hue});
        n3_x[2] = $signed({2'b00, r2_hue}) - hslargb_pkg::HUE_X_W'(hslargb_pkg::HUE_THIRD);

        for (int k = 0; k < 3; k++) begin
            if (n3_x[k] < 0) begin
                n3_x[k] = n3_x[k] + hslargb_pkg::HUE_X_W'(hslargb_pkg::HUE_TURN);
            end
            if (n3_x[k] > hslargb_pkg::HUE_X_W'(hslargb_pkg::HUE_TURN)) begin
                n3_x[k] = n3_x[k] - hslargb_pkg::HUE_X_W'(hslargb_pkg::HUE_TURN);
            end
            if (n3_x[k] < hslargb_pkg::HUE_X_W'(hslargb_pkg::HUE_SIXTH)) begin
                n3_w[k] = hslargb_pkg::WGT_W'(n3_x[k]);
            end else if (n3_x[k] < hslargb_pkg::HUE_X_W'(3 * hslargb_pkg::HUE_SIXTH)) begin
                n3_w[k] = hslargb_pkg::WGT_W'(hslargb_pkg::HUE_SIXTH);
            end else if (n3_x[k] < hslargb_pkg::HUE_X_W'(4 * hslargb_pkg::HUE_SIXTH)) begin
                n3_w[k] = hslargb_pkg::WGT_W'(
                          hslargb_pkg::HUE_X_W'(2 * hslargb_pkg::HUE_THIRD) - n3_x[k]);
            end else begin
                n3_w[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r3_prod <= hslargb_pkg::PROD_W'(w2_lit) * hslargb_pkg::PROD_W'(n3_sel);
        r3_l    <= w2_lit;
        r3_s    <= w2_sat;
        r3_low  <= n3_low;
        for (int k = 0; k < 3; k++) begin
            r3_w[k] <= n3_w[k];
        end
    end

    // ---------------- Stage 4: m2, m1 and spread --------------------------
    always_comb begin
        n4_l  = $signed({2'b00, r3_l});
        n4_s  = $signed({2'b00, r3_s});
        n4_ps = $signed(hslargb_pkg::M_W'(r3_prod >> hslargb_pkg::IFRAC));
        n4_m2 = r3_low ? n4_ps : (n4_l + n4_s - n4_ps);
        n4_m1 = (n4_l <<< 1) - n4_m2;
        n4_d  = (n4_m2 <<< 1) - (n4_l <<< 1);
    end

    always_ff @(posedge i_clk) begin
        r4_m1 <= n4_m1[hslargb_pkg::UNIT_W-1:0];
        r4_d  <= n4_d[hslargb_pkg::UNIT_W:0];
    end

    // weights wait one stage for m1 and the spread
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r3_w_hold[k] <= r3_w[k];
        end
    end

    // ---------------- Stages 5 to 8: per-channel blend and round ----------
    for (genvar g = 0; g < 3; g++) begin : g_chan
        hslargb_chan u_chan (
            .i_clk  (i_clk),
            .i_m1   (r4_m1),
            .i_d    (r4_d[hslargb_pkg::UNIT_W-1:0]),
            .i_w    (r3_w_hold[g]),
            .o_byte (w8_rgb[g])
        );
    end

    assign o_valid     = r_vld[hslargb_pkg::PIPE_DEPTH-1];
    assign o_argb_word = {r_alpha[hslargb_pkg::PIPE_DEPTH-1], w8_rgb[0], w8_rgb[1], w8_rgb[2]};

    // ---------------- Assertions ------------------------------------------
    a_result_follows_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, hslargb_pkg::PIPE_DEPTH))
        else $error("result without a matching input beat");

    a_hue_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r2_hue < hslargb_pkg::HUE_W'(hslargb_pkg::HUE_TURN)))
        else $error("reduced hue out of range");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r3_w[0] <= hslargb_pkg::WGT_W'(hslargb_pkg::HUE_SIXTH)
                   && r3_w[1] <= hslargb_pkg::WGT_W'(hslargb_pkg::HUE_SIXTH)
                   && r3_w[2] <= hslargb_pkg::WGT_W'(hslargb_pkg::HUE_SIXTH)))
        else $error("hue weight out of range");

    a_spread_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> !r4_d[hslargb_pkg::UNIT_W])
        else $error("m2 below m1");

    a_alpha_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_opacity[hslargb_pkg::IN_W-1], hslargb_pkg::PIPE_DEPTH))
        |-> (o_argb_word[31:24] == 8'd0))
        else $error("negative opacity gave nonzero alpha");

endmodule
